/* rtl/rnp_pkg.sv */
// Shared types and constants for the radix number parser.
package rnp_pkg;

  // Parameter defaults
  localparam int MaxLenDefault = 255;
  localparam logic [5:0] RadixReset = 6'd10;

  // Character codes
  localparam logic [7:0] ChDigit0 = 8'h30;  // '0'
  localparam logic [7:0] ChDigit9 = 8'h39;  // '9'
  localparam logic [7:0] ChUpperA = 8'h41;  // 'A'
  localparam logic [7:0] ChUpperZ = 8'h5A;  // 'Z'
  localparam logic [7:0] ChLowerA = 8'h61;  // 'a'
  localparam logic [7:0] ChLowerZ = 8'h7A;  // 'z'
  localparam logic [7:0] ChMinus  = 8'h2D;  // '-'
  localparam logic [5:0] LetterBase = 6'd10;

  // One input request as held in the input register
  typedef struct packed {
    logic [7:0]  character;
    logic        first;
    logic        last;
    logic [63:0] start_value;
  } in_item_t;

  // Decoded digit: valid for the current radix, and its weight
  typedef struct packed {
    logic       valid;
    logic [5:0] value;
  } digit_t;

endpackage

/* rtl/rnp_digit_decode.sv */
// Character to digit decoder for a configurable radix.
module rnp_digit_decode (
  input  logic [7:0]     character,
  input  logic [5:0]     radix,
  output rnp_pkg::digit_t digit
);

  logic       is_char;
  logic [7:0] raw;

  // Map the character ranges onto digit weights
  always_comb begin
    is_char = 1'b1;
    raw     = 8'd0;
    priority if (character >= rnp_pkg::ChDigit0 && character <= rnp_pkg::ChDigit9) begin
      raw = character - rnp_pkg::ChDigit0;
    end else if (character >= rnp_pkg::ChUpperA && character <= rnp_pkg::ChUpperZ) begin
      raw = character - rnp_pkg::ChUpperA + 8'(rnp_pkg::LetterBase);
    end else if (character >= rnp_pkg::ChLowerA && character <= rnp_pkg::ChLowerZ) begin
      raw = character - rnp_pkg::ChLowerA + 8'(rnp_pkg::LetterBase);
    end else begin
      is_char = 1'b0;
    end
  end

  // Accept only weights below the radix
  assign digit.value = raw[5:0];
  assign digit.valid = is_char && (raw[5:0] < radix);

endmodule

/* rtl/radix_number_parser.sv */
// Top level of the radix number parser: input register, convert stage, result register.
//
//  channel | dir | tdata (low bit up)                      | tuser    | tlast
//  s_*     | in  | character[7:0], start_value[71:8]       | first    | last
//  m_*     | out | value[63:0], consumed[71:64],            | complete | -
//          |     | unconverted[79:72]                      |          |
//  radix   | cfg | radix_we / radix_wdata[5:0], no readback |          |
//
// One character is accepted every cycle while the input is not held; a result is loaded
// when the last request leaves the input register. The rate is set by the accumulate
// loop: one 64x6 multiply-add per cycle on the stored accumulator in the convert stage.
// Synchronous reset clears the parser state and sets the radix to 10.
// Requests without a result pass while the result register waits; only a
// last request meeting a full, stalled result register holds the input.
module radix_number_parser #(
  parameter int MAX_LEN = rnp_pkg::MaxLenDefault
) (
  input  logic        clk,
  input  logic        rst,
  // configuration
  input  logic        radix_we,
  input  logic [5:0]  radix_wdata,
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [71:0] s_tdata,   // character[7:0], start_value[71:8]
  input  logic        s_tuser,   // first
  input  logic        s_tlast,   // last
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [79:0] m_tdata,   // value[63:0], consumed[71:64], unconverted[79:72]
  output logic        m_tuser    // complete
);

  localparam logic [7:0] CountCap = (MAX_LEN < 255) ? 8'(MAX_LEN) : 8'd255;

  logic [5:0]        radix;
  logic              s1_valid;
  rnp_pkg::in_item_t s1_item;
  logic              fire;

  logic [63:0] accumulator, accumulator_next;
  logic        negative_seen, negative_seen_next;
  logic        stopped, stopped_next;
  logic [7:0]  consumed_count, consumed_count_next;
  logic [7:0]  total_count, total_count_next;

  logic [63:0] acc_base;
  logic        neg_base, stop_base;
  logic [7:0]  cc_base, tc_base;
  logic [69:0] product;
  rnp_pkg::digit_t digit;

  logic [63:0] value_out;
  logic [7:0]  consumed_out, unconverted_out;
  logic        complete_out;

  // Radix register
  always_ff @(posedge clk) begin
    if (rst) begin
      radix <= rnp_pkg::RadixReset;
    end else if (radix_we) begin
      radix <= radix_wdata;
    end
  end

  // Convert stage advances unless a result would overwrite a waiting one
  assign fire     = s1_valid && !(s1_item.last && m_tvalid && !m_tready);
  assign s_tready = !s1_valid || fire;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_tready) begin
      s1_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      s1_item.character   <= s_tdata[7:0];
      s1_item.start_value <= s_tdata[71:8];
      s1_item.first       <= s_tuser;
      s1_item.last        <= s_tlast;
    end
  end

  rnp_digit_decode u_digit (
    .character (s1_item.character),
    .radix     (radix),
    .digit     (digit)
  );

  // Restart the state on first, then take one character
  always_comb begin
    acc_base  = s1_item.first ? s1_item.start_value : accumulator;
    neg_base  = s1_item.first ? 1'b0 : negative_seen;
    stop_base = s1_item.first ? 1'b0 : stopped;
    cc_base   = s1_item.first ? 8'd0 : consumed_count;
    tc_base   = s1_item.first ? 8'd0 : total_count;
    product   = acc_base * radix;

    accumulator_next    = acc_base;
    negative_seen_next  = neg_base;
    stopped_next        = stop_base;
    consumed_count_next = cc_base;
    total_count_next    = tc_base;

    if (tc_base < CountCap) begin
      priority if (s1_item.first && s1_item.character == rnp_pkg::ChMinus) begin
        negative_seen_next  = 1'b1;
        consumed_count_next = cc_base + 8'd1;
      end else if (!stop_base) begin
        if (digit.valid) begin
          accumulator_next    = product[63:0] + 64'(digit.value);
          consumed_count_next = cc_base + 8'd1;
        end else begin
          stopped_next = 1'b1;
        end
      end
      total_count_next = tc_base + 8'd1;
    end

    value_out       = negative_seen_next ? (64'd0 - accumulator_next) : accumulator_next;
    consumed_out    = consumed_count_next;
    unconverted_out = total_count_next - consumed_count_next;
    complete_out    = !stopped_next;
  end

  // Parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      accumulator    <= 64'd0;
      negative_seen  <= 1'b0;
      stopped        <= 1'b0;
      consumed_count <= 8'd0;
      total_count    <= 8'd0;
    end else if (fire) begin
      accumulator    <= accumulator_next;
      negative_seen  <= negative_seen_next;
      stopped        <= stopped_next;
      consumed_count <= consumed_count_next;
      total_count    <= total_count_next;
    end
  end

  // Result register: load on a last request, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (fire && s1_item.last) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && s1_item.last) begin
      m_tdata <= {unconverted_out, consumed_out, value_out};
      m_tuser <= complete_out;
    end
  end

  // Checks
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (s1_valid && s1_item.last && m_tvalid && !m_tready))
    else $error("input held without a blocked result");

  a_count_order: assert property (@(posedge clk) disable iff (rst)
    consumed_count <= total_count)
    else $error("consumed count exceeds total count");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(fire && s1_item.last))
    else $error("result without a last request");

  a_radix_reset: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> (radix == rnp_pkg::RadixReset))
    else $error("radix not restored by reset");

endmodule

/* test/tb_top.sv */
// Self-checking testbench for radix_number_parser: directed and random strings.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CountCap = (rnp_pkg::MaxLenDefault < 255) ? rnp_pkg::MaxLenDefault : 255;
  localparam int PhaseItems = 36;
  localparam int CapRunLen = 270;
  localparam logic [5:0] RadixPlan [9] = '{6'd2, 6'd36, 6'd16, 6'd0, 6'd1, 6'd63, 6'd37,
                                           6'd8, 6'd10};

  typedef struct packed {
    logic [63:0] value;
    logic [7:0]  consumed;
    logic [7:0]  unconverted;
    logic        complete;
  } parse_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        radix_we = 1'b0;
  logic [5:0]  radix_wdata = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [71:0] s_tdata = '0;   // character[7:0], start_value[71:8]
  logic        s_tuser = 1'b0; // first
  logic        s_tlast = 1'b0; // last
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [79:0] m_tdata;        // value[63:0], consumed[71:64], unconverted[79:72]
  logic        m_tuser;        // complete

  radix_number_parser dut (
    .clk        (clk),
    .rst        (rst),
    .radix_we   (radix_we),
    .radix_wdata(radix_wdata),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .s_tlast    (s_tlast),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser)
  );

  always #5 clk = ~clk;

  // Characters waiting to be sent and parse results waiting to arrive
  rnp_pkg::in_item_t char_q[$];
  parse_result_t     parse_result_q[$];
  int                errors = 0;

  // Parser state as predicted
  logic [5:0]  cfg_radix = rnp_pkg::RadixReset;
  logic [63:0] parse_acc = '0;
  logic        parse_neg = 1'b0;
  logic        parse_stopped = 1'b0;
  int          parse_consumed = 0;
  int          parse_total = 0;

  // Weight of a character in the given radix, or -1 when it is no digit there
  function automatic int digit_weight(logic [7:0] c, logic [5:0] r);
    int w;
    if (c >= rnp_pkg::ChDigit0 && c <= rnp_pkg::ChDigit9) begin
      w = int'(c) - int'(rnp_pkg::ChDigit0);
    end else if (c >= rnp_pkg::ChUpperA && c <= rnp_pkg::ChUpperZ) begin
      w = int'(c) - int'(rnp_pkg::ChUpperA) + int'(rnp_pkg::LetterBase);
    end else if (c >= rnp_pkg::ChLowerA && c <= rnp_pkg::ChLowerZ) begin
      w = int'(c) - int'(rnp_pkg::ChLowerA) + int'(rnp_pkg::LetterBase);
    end else begin
      return -1;
    end
    return (w < int'(r)) ? w : -1;
  endfunction

  // Advance the predicted state by one accepted character; queue a result on last
  task automatic parse_char(input rnp_pkg::in_item_t it);
    int            d;
    parse_result_t res;
    if (it.first) begin
      parse_acc = it.start_value;
      parse_neg = 1'b0;
      parse_stopped = 1'b0;
      parse_consumed = 0;
      parse_total = 0;
    end
    if (parse_total < CountCap) begin
      if (it.first && it.character == rnp_pkg::ChMinus) begin
        parse_neg = 1'b1;
        parse_consumed++;
      end else if (!parse_stopped) begin
        d = digit_weight(it.character, cfg_radix);
        if (d < 0) begin
          parse_stopped = 1'b1;
        end else begin
          parse_acc = parse_acc * {58'd0, cfg_radix} + 64'(d);
          parse_consumed++;
        end
      end
      parse_total++;
    end
    if (it.last) begin
      res.value = parse_neg ? 64'd0 - parse_acc : parse_acc;
      res.consumed = 8'(parse_consumed);
      res.unconverted = 8'(parse_total - parse_consumed);
      res.complete = !parse_stopped;
      parse_result_q.push_back(res);
    end
  endtask

  // A random character that is a digit of the radix, where the radix has any
  function automatic logic [7:0] digit_char(logic [5:0] r);
    int lim;
    int v;
    lim = (r > 36) ? 36 : int'(r);
    if (lim == 0) return 8'($urandom);
    v = $urandom_range(0, lim - 1);
    if (v < 10) return rnp_pkg::ChDigit0 + 8'(v);
    if ($urandom_range(0, 1) == 1) return rnp_pkg::ChUpperA + 8'(v - 10);
    return rnp_pkg::ChLowerA + 8'(v - 10);
  endfunction

  task automatic push_char(logic [7:0] c, logic f, logic l, logic [63:0] sv);
    rnp_pkg::in_item_t it;
    it.character = c;
    it.first = f;
    it.last = l;
    it.start_value = sv;
    char_q.push_back(it);
  endtask

  task automatic push_string(string s, logic [63:0] sv);
    for (int i = 0; i < s.len(); i++) push_char(s[i], i == 0, i == s.len() - 1, sv);
  endtask

  // Mostly well-formed strings with random digits, the rest loose characters
  task automatic random_strings(int n);
    int         made;
    int         len;
    logic [63:0] sv;
    logic [7:0] c;
    made = 0;
    while (made < n) begin
      if ($urandom_range(0, 9) < 8) begin
        len = $urandom_range(1, 12);
        case ($urandom_range(0, 3))
          0, 1: sv = '0;
          2: sv = {$urandom, $urandom};
          default: sv = '1;
        endcase
        for (int i = 0; i < len; i++) begin
          if (i == 0 && $urandom_range(0, 3) == 0) c = rnp_pkg::ChMinus;
          else if ($urandom_range(0, 9) == 0) c = 8'($urandom);
          else c = digit_char(cfg_radix);
          // start value only counts on the first character
          push_char(c, i == 0, i == len - 1, (i == 0) ? sv : {$urandom, $urandom});
        end
        made += len;
      end else begin
        push_char(8'($urandom), 1'($urandom), 1'($urandom), {$urandom, $urandom});
        made++;
      end
    end
  endtask

  // Hold until every request is sent and every result is in, then let the pipe drain
  task automatic wait_idle();
    do @(posedge clk);
    while (char_q.size() != 0 || s_tvalid || parse_result_q.size() != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_radix(logic [5:0] r);
    @(posedge clk);
    radix_we <= 1'b1;
    radix_wdata <= r;
    @(posedge clk);
    radix_we <= 1'b0;
    cfg_radix = r;
  endtask

  // Send requests in bursts of random length with random gaps
  int burst_left = 0;
  int gap_left = 0;
  always @(posedge clk) begin
    rnp_pkg::in_item_t nxt;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || s_tready) begin
      if (gap_left > 0) begin
        gap_left--;
        s_tvalid <= 1'b0;
      end else if (char_q.size() > 0) begin
        nxt = char_q.pop_front();
        s_tdata <= {nxt.start_value, nxt.character};
        s_tuser <= nxt.first;
        s_tlast <= nxt.last;
        s_tvalid <= 1'b1;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 24);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Predict on every accepted request
  always @(posedge clk) begin
    rnp_pkg::in_item_t seen;
    if (!rst && s_tvalid && s_tready) begin
      seen.character = s_tdata[7:0];
      seen.first = s_tuser;
      seen.last = s_tlast;
      seen.start_value = s_tdata[71:8];
      parse_char(seen);
    end
  end

  // Stall the result side on a random pattern, reloaded each time the phase counter wraps
  logic [15:0] ready_pattern = '1;
  int          ready_phase = 0;
  always @(posedge clk) begin
    if (ready_phase == 0) begin
      ready_pattern = ($urandom_range(0, 3) == 0) ? 16'hffff : (16'($urandom) | 16'h0001);
    end
    m_tready <= ready_pattern[ready_phase % 16];
    ready_phase = (ready_phase + 1) % 64;
  end

  // Compare each result with the oldest prediction
  always @(posedge clk) begin
    parse_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (parse_result_q.size() == 0) begin
        $error("result with no prediction waiting: value %h", m_tdata[63:0]);
        errors++;
      end else begin
        want = parse_result_q.pop_front();
        if (m_tdata[63:0] !== want.value) begin
          $error("value: expected %h, got %h", want.value, m_tdata[63:0]);
          errors++;
        end
        if (m_tdata[71:64] !== want.consumed) begin
          $error("consumed: expected %0d, got %0d", want.consumed, m_tdata[71:64]);
          errors++;
        end
        if (m_tdata[79:72] !== want.unconverted) begin
          $error("unconverted: expected %0d, got %0d", want.unconverted, m_tdata[79:72]);
          errors++;
        end
        if (m_tuser !== want.complete) begin
          $error("complete: expected %0b, got %0b", want.complete, m_tuser);
          errors++;
        end
      end
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed strings at the reset radix
    push_char(rnp_pkg::ChDigit0 + 8'd7, 1'b0, 1'b1, '0);    // no first since reset
    push_string("-", 64'd5);                                 // sign only
    push_string("-42", '0);
    push_string("1-2", '1);                                  // minus after the first character
    push_char(8'hff, 1'b1, 1'b1, 64'h8000_0000_0000_0000);   // high byte stops at once
    push_string("0", '0);
    push_string("9Z", '1);                                   // letter above the radix
    push_char(rnp_pkg::ChMinus, 1'b1, 1'b0, 64'd123);        // sign, then a high byte
    push_char(8'h80, 1'b0, 1'b0, '0);
    push_char(rnp_pkg::ChDigit0 + 8'd5, 1'b0, 1'b1, '0);
    push_char(8'h00, 1'b1, 1'b0, '0);
    push_char(rnp_pkg::ChDigit0 + 8'd3, 1'b0, 1'b1, '0);
    push_char(rnp_pkg::ChDigit0 + 8'd4, 1'b0, 1'b1, '0);    // carry on without a new first
    wait_idle();

    // Random strings under each radix setting
    foreach (RadixPlan[p]) begin
      set_radix(RadixPlan[p]);
      random_strings(PhaseItems);
      if (RadixPlan[p] == 6'd16) begin
        // run past the length cap; the trailing characters are ignored
        for (int i = 0; i < CapRunLen; i++) begin
          push_char(digit_char(cfg_radix), i == 0, i == CapRunLen - 1, {$urandom, $urandom});
        end
      end
      wait_idle();
    end
    set_radix(6'($urandom_range(2, 36)));
    random_strings(PhaseItems);
    wait_idle();

    if (parse_result_q.size() != 0) begin
      $error("%0d results never arrived", parse_result_q.size());
      errors++;
    end
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    #5_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
